@@ hw/rtl/eight_bit_alu_with_bcd_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the eight-bit ALU with BCD unit
// Concurrent checks on clock with synchronous active-high reset; they are
// empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef EIGHT_BIT_ALU_WITH_BCD_UNIT_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_BCD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent
`define EBALU_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ebalu assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define EBALU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ebalu assertion failed");

`else

`define EBALU_ASSERT_SAME(lbl, ante, cons)
`define EBALU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/ebalu_pkg.sv @@
// ---------------------------------------------------------------------------
// ebalu_pkg
// Operation codes and transaction layouts shared by the ALU core and the
// top level.
// ---------------------------------------------------------------------------
package ebalu_pkg;

   localparam int unsigned OpWidth      = 5;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 16;

   // Operation codes
   typedef enum logic [OpWidth-1:0] {
      OP_ADC = 5'd0,
      OP_SBC = 5'd1,
      OP_AND = 5'd2,
      OP_ORA = 5'd3,
      OP_EOR = 5'd4,
      OP_CMP = 5'd5,
      OP_BIT = 5'd6,
      OP_ASL = 5'd7,
      OP_LSR = 5'd8,
      OP_ROL = 5'd9,
      OP_ROR = 5'd10,
      OP_INC = 5'd11,
      OP_DEC = 5'd12,
      OP_ALR = 5'd13,
      OP_ANC = 5'd14,
      OP_ARR = 5'd15,
      OP_AXS = 5'd16
   } op_type;

   // Request data, first member in the highest bits, accumulator lowest
   typedef struct packed {
      logic                 negative_in;
      logic                 zero_in;
      logic                 overflow_in;
      logic                 decimal_in;
      logic                 carry_in;
      logic [ByteWidth-1:0] operand;
      logic [ByteWidth-1:0] x_value;
      logic [ByteWidth-1:0] acc_value;
   } req_data_type;

   // Response data, result byte lowest
   typedef struct packed {
      logic                 negative_out;
      logic                 zero_out;
      logic                 overflow_out;
      logic                 carry_out;
      logic [ByteWidth-1:0] result;
   } rsp_data_type;

   localparam int unsigned ReqPadWidth = ReqDataWidth - $bits(req_data_type);
   localparam int unsigned RspPadWidth = RspDataWidth - $bits(rsp_data_type);

endpackage

@@ hw/rtl/eight_bit_alu_with_bcd_unit.sv @@
// ---------------------------------------------------------------------------
// eight_bit_alu_with_bcd_unit
// 8-bit processor ALU with decimal add/subtract: input register, one
// combinational pass through the core, result register.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_tvalid/tready    | tuser op_code, tdata operands
//  rsp     | out       | rsp_tvalid/tready    | tdata result and flags
//  csr     | in        | csr_valid/csr_ready  | csr_data = cmos_variant
//
// One transaction per cycle while rsp_tready keeps the result flowing; an
// accepted request passes the input register, then the result register.
// A stalled result holds in the result register while the input register
// still takes a new transaction; the pipeline stops only when both are full.
// Synchronous reset empties both stages and clears cmos_variant.
// ---------------------------------------------------------------------------
`include "eight_bit_alu_with_bcd_unit_defines.svh"

module eight_bit_alu_with_bcd_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] acc_value, [15:8] x_value, [23:16] operand, [24] carry_in,
   // [25] decimal_in, [26] overflow_in, [27] zero_in, [28] negative_in
   input  logic [ebalu_pkg::ReqDataWidth-1:0] req_tdata,
   // [4:0] op_code
   input  logic [ebalu_pkg::OpWidth-1:0]      req_tuser,
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] result, [8] carry_out, [9] overflow_out, [10] zero_out,
   // [11] negative_out
   output logic [ebalu_pkg::RspDataWidth-1:0] rsp_tdata,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data
);
   import ebalu_pkg::*;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   req_data_type         s1_data_ff;
   logic [OpWidth-1:0]   s1_op_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_data_type         rsp_data_ff;
   rsp_data_type         core_data;
   logic                 cmos_ff;
   logic                 cmos_in;
   logic                 s1_ready;
   logic                 s2_ready;

   // Stage readiness
   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign csr_ready  = 1'b1;

   // Next valid and configuration values
   assign s1_valid_in  = s1_ready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
   assign cmos_in      = csr_valid ? csr_data : cmos_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmos_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmos_ff      <= cmos_in;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         s1_data_ff <= req_data_type'(req_tdata[$bits(req_data_type)-1:0]);
         s1_op_ff   <= req_tuser;
      end
   end

   // Capture the result
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         rsp_data_ff <= core_data;
      end
   end

   ebalu_core u_core (
      .op_code      (s1_op_ff),
      .req_data     (s1_data_ff),
      .cmos_variant (cmos_ff),
      .rsp_data     (core_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RspPadWidth{1'b0}}, rsp_data_ff};

   // Checks
   `EBALU_ASSERT_NEXT(a_stage_advance, s1_valid_ff && s2_ready, rsp_valid_ff)
   `EBALU_ASSERT_SAME(a_empty_ready, !s1_valid_ff && !rsp_valid_ff, req_tready)
   `EBALU_ASSERT_NEXT(a_nop_passes, s1_valid_ff && s2_ready && (s1_op_ff > OP_AXS), rsp_data_ff.result == $past(s1_data_ff.acc_value) && rsp_data_ff.carry_out == $past(s1_data_ff.carry_in))

endmodule

@@ hw/rtl/ebalu_core.sv @@
// ---------------------------------------------------------------------------
// ebalu_core
// Combinational datapath: binary and decimal add/subtract, logic ops,
// compare, shifts, increment/decrement and the flag logic.
// ---------------------------------------------------------------------------
module ebalu_core (
   input  logic [ebalu_pkg::OpWidth-1:0] op_code,
   input  ebalu_pkg::req_data_type       req_data,
   input  logic                          cmos_variant,
   output ebalu_pkg::rsp_data_type       rsp_data
);
   import ebalu_pkg::*;

   function automatic logic is_zero(input logic [ByteWidth-1:0] val);
      return (val == '0);
   endfunction

   logic [ByteWidth-1:0] a;
   logic [ByteWidth-1:0] m;
   logic                 ci;
   op_type               op;

   // Shared binary adder
   logic [ByteWidth-1:0] m_eff;
   logic [ByteWidth:0]   bsum;
   logic                 bvflag;

   // Decimal add
   logic [4:0] dlo;
   logic [5:0] dlo_adj;
   logic [9:0] dsum;
   logic       dhi_adj;
   logic       dvflag;
   logic [7:0] dres;

   // Decimal subtract
   logic [4:0] slo;
   logic       slo_neg;
   logic [5:0] shi;
   logic [3:0] sres_lo;
   logic [3:0] sres_hi;

   // Compare subtractor
   logic [ByteWidth-1:0] cmp_lhs;
   logic [ByteWidth:0]   cmp_diff;
   logic [ByteWidth-1:0] and_am;

   assign a  = req_data.acc_value;
   assign m  = req_data.operand;
   assign ci = req_data.carry_in;
   assign op = op_type'(op_code);

   // Binary add; subtract adds the inverted operand
   assign m_eff  = (op == OP_SBC) ? ~m : m;
   assign bsum   = {1'b0, a} + {1'b0, m_eff} + {{ByteWidth{1'b0}}, ci};
   assign bvflag = (a[7] ^ bsum[7]) & (m_eff[7] ^ bsum[7]);

   // Decimal add with nibble adjust
   assign dlo     = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, ci};
   assign dlo_adj = (dlo > 5'd9) ? ({1'b0, dlo} + 6'd6) : {1'b0, dlo};
   assign dsum    = {4'b0, dlo_adj} + {2'b0, a[7:4], 4'b0} + {2'b0, m[7:4], 4'b0};
   assign dhi_adj = (dsum >= 10'h0A0);
   assign dvflag  = (a[7] ^ dsum[7]) & (m[7] ^ dsum[7]);
   assign dres    = dsum[7:0] + (dhi_adj ? 8'h60 : 8'h00);

   // Decimal subtract with nibble adjust, borrow passed to the high nibble
   assign slo     = {1'b0, a[3:0]} - {1'b0, m[3:0]} - {4'b0, ~ci};
   assign slo_neg = slo[4];
   assign sres_lo = slo_neg ? (slo[3:0] - 4'd6) : slo[3:0];
   assign shi     = {2'b0, a[7:4]} - {2'b0, m[7:4]} - {5'b0, slo_neg};
   assign sres_hi = shi[5] ? (shi[3:0] - 4'd6) : shi[3:0];

   // Compare and AXS subtract
   assign and_am   = a & m;
   assign cmp_lhs  = (op == OP_AXS) ? (a & req_data.x_value) : a;
   assign cmp_diff = {1'b0, cmp_lhs} - {1'b0, m};

   // Select result and flags
   always_comb begin
      logic [ByteWidth-1:0] r;
      logic c, v, z, n;
      r = a;
      c = ci;
      v = req_data.overflow_in;
      z = req_data.zero_in;
      n = req_data.negative_in;
      case (op)
         OP_ADC: begin
            if (req_data.decimal_in) begin
               r = dres;
               c = dhi_adj;
               v = dvflag;
               n = dres[7];
               z = cmos_variant ? is_zero(dres) : is_zero(bsum[7:0]);
            end else begin
               r = bsum[7:0];
               c = bsum[8];
               v = bvflag;
               z = is_zero(r);
               n = r[7];
            end
         end
         OP_SBC: begin
            c = bsum[8];
            v = bvflag;
            r = req_data.decimal_in ? {sres_hi, sres_lo} : bsum[7:0];
            z = is_zero(r);
            n = r[7];
         end
         OP_AND: begin
            r = and_am;
            z = is_zero(r);
            n = r[7];
         end
         OP_ORA: begin
            r = a | m;
            z = is_zero(r);
            n = r[7];
         end
         OP_EOR: begin
            r = a ^ m;
            z = is_zero(r);
            n = r[7];
         end
         OP_CMP: begin
            c = ~cmp_diff[8];
            z = is_zero(cmp_diff[7:0]);
            n = cmp_diff[7];
         end
         OP_BIT: begin
            z = is_zero(and_am);
            n = m[7];
            v = m[6];
         end
         OP_ASL: begin
            c = m[7];
            r = {m[6:0], 1'b0};
            z = is_zero(r);
            n = r[7];
         end
         OP_LSR: begin
            c = m[0];
            r = {1'b0, m[7:1]};
            z = is_zero(r);
            n = r[7];
         end
         OP_ROL: begin
            c = m[7];
            r = {m[6:0], ci};
            z = is_zero(r);
            n = r[7];
         end
         OP_ROR: begin
            c = m[0];
            r = {ci, m[7:1]};
            z = is_zero(r);
            n = r[7];
         end
         OP_INC: begin
            r = m + 8'd1;
            z = is_zero(r);
            n = r[7];
         end
         OP_DEC: begin
            r = m - 8'd1;
            z = is_zero(r);
            n = r[7];
         end
         OP_ALR: begin
            c = and_am[0];
            r = {1'b0, and_am[7:1]};
            z = is_zero(r);
            n = r[7];
         end
         OP_ANC: begin
            r = and_am;
            z = is_zero(r);
            n = r[7];
            c = r[7];
         end
         OP_ARR: begin
            r = {ci, and_am[7:1]};
            z = is_zero(r);
            n = r[7];
            c = r[6];
            v = r[6] ^ r[5];
         end
         OP_AXS: begin
            c = ~cmp_diff[8];
            r = cmp_diff[7:0];
            z = is_zero(r);
            n = r[7];
         end
         default: begin
            r = a;
         end
      endcase
      rsp_data.result       = r;
      rsp_data.carry_out    = c;
      rsp_data.overflow_out = v;
      rsp_data.zero_out     = z;
      rsp_data.negative_out = n;
   end

endmodule
